// ----- rtl/core/srtd_pkg.sv -----
`timescale 1ns / 1ps

package srtd_pkg;

   localparam logic [15:0] EMPTY_WORD = 16'hFFFF;

   localparam int unsigned MIN_PER_DAY   = 1440;
   localparam int unsigned MIN_PER_HOUR  = 60;
   localparam int unsigned HOURS_PER_DAY = 24;
   localparam int unsigned MONTH_TOP     = 12;
   localparam int unsigned YEAR_TOP      = 99;

   // floor(x / 1440) == (x * 46604) >> 26 for every 16-bit x
   localparam int unsigned DAY_RECIP  = 46604;
   localparam int unsigned DAY_SHIFT  = 26;
   // floor(x / 60) == (x * 1093) >> 16 for every x below 1440
   localparam int unsigned HOUR_RECIP = 1093;
   localparam int unsigned HOUR_SHIFT = 16;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_CENTURY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_YEAR    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_MONTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_DAY     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_HOUR    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_MINUTE  = 3'd5;

   typedef struct packed {
      logic [6:0] century;
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
   } cfg_type;

   typedef struct packed {
      logic [5:0]  days;
      logic [4:0]  hours;
      logic [5:0]  mins;
      logic [11:0] reading;
      logic [3:0]  channel;
   } split_type;

   // packed so that channel sits in the lowest bits, as on the result bus
   typedef struct packed {
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [6:0]  year;
      logic [6:0]  century;
      logic [11:0] reading;
      logic [3:0]  channel;
   } rslt_type;

endpackage

// ----- rtl/core/srtd_split.sv -----
`timescale 1ns / 1ps

module srtd_split
   import srtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [15:0] in_offset,
   input  logic [15:0] in_raw,
   output logic        out_valid,
   input  logic        out_ready,
   output split_type   out_data
);

   logic        s1_ready, s2_ready, s3_ready, s4_ready;
   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic        s1_valid_in;

   logic [5:0]  s1_days_ff,  s2_days_ff,  s3_days_ff;
   logic [15:0] s1_offset_ff;
   logic [15:0] s1_raw_ff,   s2_raw_ff,   s3_raw_ff;
   logic [10:0] s2_rest_ff,  s3_rest_ff;
   logic [4:0]  s3_hours_ff;
   split_type   s4_data_ff;

   logic [31:0] day_prod;
   logic [5:0]  s1_days_in;
   logic [16:0] day_base;
   logic [16:0] rest_wide;
   logic [20:0] hour_prod;
   logic [4:0]  s3_hours_in;
   logic [10:0] mins_wide;
   split_type   s4_data_in;

   // drop empty records at the door: they take a beat but leave no result
   assign s1_valid_in = in_valid && (in_offset != EMPTY_WORD) && (in_raw != EMPTY_WORD);

   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s4_ready = !s4_valid_ff || out_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= s1_valid_in;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: days by reciprocal multiply
   assign day_prod   = 32'(in_offset) * 32'(DAY_RECIP);
   assign s1_days_in = day_prod[DAY_SHIFT +: 6];

   always_ff @(posedge clock) begin
      if (s1_ready && s1_valid_in) begin
         s1_days_ff   <= s1_days_in;
         s1_offset_ff <= in_offset;
         s1_raw_ff    <= in_raw;
      end
   end

   // stage 2: minutes left within the day
   assign day_base  = 17'(s1_days_ff) * 17'(MIN_PER_DAY);
   assign rest_wide = 17'(s1_offset_ff) - day_base;

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_days_ff <= s1_days_ff;
         s2_rest_ff <= rest_wide[10:0];
         s2_raw_ff  <= s1_raw_ff;
      end
   end

   // stage 3: hours by reciprocal multiply
   assign hour_prod   = 21'(s2_rest_ff) * 21'(HOUR_RECIP);
   assign s3_hours_in = hour_prod[HOUR_SHIFT +: 5];

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_days_ff  <= s2_days_ff;
         s3_rest_ff  <= s2_rest_ff;
         s3_hours_ff <= s3_hours_in;
         s3_raw_ff   <= s2_raw_ff;
      end
   end

   // stage 4: minutes left within the hour, unpack the sensor word
   assign mins_wide = s3_rest_ff - 11'(s3_hours_ff) * 11'(MIN_PER_HOUR);

   always_comb begin
      s4_data_in.days    = s3_days_ff;
      s4_data_in.hours   = s3_hours_ff;
      s4_data_in.mins    = mins_wide[5:0];
      s4_data_in.reading = s3_raw_ff[15:4];
      s4_data_in.channel = s3_raw_ff[3:0];
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

// ----- rtl/core/srtd_cal.sv -----
`timescale 1ns / 1ps

module srtd_cal
   import srtd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   output logic      in_ready,
   input  split_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output rslt_type  out_data
);

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         default: len = 5'd30;
      endcase
      return len;
   endfunction

   logic        c1_ready, c2_ready, c3_ready;
   logic        c1_valid_ff, c2_valid_ff, c3_valid_ff;

   logic [5:0]  c1_minute_ff, c2_minute_ff;
   logic [5:0]  c1_hour_sum_ff;
   logic [5:0]  c1_days_ff;
   logic [11:0] c1_reading_ff, c2_reading_ff;
   logic [3:0]  c1_channel_ff, c2_channel_ff;
   logic [4:0]  c2_hour_ff;
   logic [6:0]  c2_day_sum_ff;
   rslt_type    c3_data_ff;

   logic [6:0]  min_sum;
   logic [6:0]  min_fix;
   logic        min_carry;
   logic [5:0]  c1_hour_sum_in;
   logic [5:0]  hour_fix;
   logic        hour_carry;
   logic [6:0]  c2_day_sum_in;
   logic [4:0]  dim;
   logic [6:0]  day_fix;
   logic        day_carry;
   logic [4:0]  month_sum;
   logic        month_carry;
   logic [7:0]  year_sum;
   rslt_type    c3_data_in;

   assign c1_ready = !c1_valid_ff || c2_ready;
   assign c2_ready = !c2_valid_ff || c3_ready;
   assign c3_ready = !c3_valid_ff || out_ready;
   assign in_ready = c1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
      end else begin
         if (c1_ready) c1_valid_ff <= in_valid;
         if (c2_ready) c2_valid_ff <= c1_valid_ff;
         if (c3_ready) c3_valid_ff <= c2_valid_ff;
      end
   end

   // stage 1: minute, one carry that may remove up to two hours' worth
   always_comb begin
      min_sum   = 7'(cfg.minute) + 7'(in_data.mins);
      min_carry = 1'b1;
      if (min_sum >= 7'(2 * MIN_PER_HOUR)) begin
         min_fix = min_sum - 7'(2 * MIN_PER_HOUR);
      end else if (min_sum >= 7'(MIN_PER_HOUR)) begin
         min_fix = min_sum - 7'(MIN_PER_HOUR);
      end else begin
         min_fix   = min_sum;
         min_carry = 1'b0;
      end
      c1_hour_sum_in = 6'(cfg.hour) + 6'(in_data.hours) + 6'(min_carry);
   end

   always_ff @(posedge clock) begin
      if (c1_ready && in_valid) begin
         c1_minute_ff   <= min_fix[5:0];
         c1_hour_sum_ff <= c1_hour_sum_in;
         c1_days_ff     <= in_data.days;
         c1_reading_ff  <= in_data.reading;
         c1_channel_ff  <= in_data.channel;
      end
   end

   // stage 2: hour
   always_comb begin
      hour_carry = 1'b1;
      if (c1_hour_sum_ff >= 6'(2 * HOURS_PER_DAY)) begin
         hour_fix = c1_hour_sum_ff - 6'(2 * HOURS_PER_DAY);
      end else if (c1_hour_sum_ff >= 6'(HOURS_PER_DAY)) begin
         hour_fix = c1_hour_sum_ff - 6'(HOURS_PER_DAY);
      end else begin
         hour_fix   = c1_hour_sum_ff;
         hour_carry = 1'b0;
      end
      c2_day_sum_in = 7'(cfg.day) + 7'(c1_days_ff) + 7'(hour_carry);
   end

   always_ff @(posedge clock) begin
      if (c2_ready && c1_valid_ff) begin
         c2_hour_ff    <= hour_fix[4:0];
         c2_day_sum_ff <= c2_day_sum_in;
         c2_minute_ff  <= c1_minute_ff;
         c2_reading_ff <= c1_reading_ff;
         c2_channel_ff <= c1_channel_ff;
      end
   end

   // stage 3: day modulo the start month's length, then month, year, century
   always_comb begin
      dim       = month_len(cfg.month, cfg.year[1:0] == 2'd0);
      day_carry = 1'b0;
      day_fix   = c2_day_sum_ff;
      if (c2_day_sum_ff > 7'(dim)) begin
         day_carry = 1'b1;
         // the sum stays below three month lengths
         if (c2_day_sum_ff >= 7'({dim, 1'b0})) begin
            day_fix = c2_day_sum_ff - 7'({dim, 1'b0});
         end else begin
            day_fix = c2_day_sum_ff - 7'(dim);
         end
      end

      month_sum   = 5'(cfg.month) + 5'(day_carry);
      month_carry = month_sum > 5'(MONTH_TOP);
      year_sum    = 8'(cfg.year) + 8'(month_carry);

      c3_data_in.channel = c2_channel_ff;
      c3_data_in.reading = c2_reading_ff;
      c3_data_in.minute  = c2_minute_ff;
      c3_data_in.hour    = c2_hour_ff;
      c3_data_in.day     = day_fix[4:0];
      c3_data_in.month   = month_carry ? 4'd1 : month_sum[3:0];
      if (year_sum > 8'(YEAR_TOP)) begin
         c3_data_in.year    = 7'd0;
         c3_data_in.century = cfg.century + 7'd1;
      end else begin
         c3_data_in.year    = year_sum[6:0];
         c3_data_in.century = cfg.century;
      end
   end

   always_ff @(posedge clock) begin
      if (c3_ready && c2_valid_ff) begin
         c3_data_ff <= c3_data_in;
      end
   end

   assign out_valid = c3_valid_ff;
   assign out_data  = c3_data_ff;

endmodule

// ----- rtl/core/sensor_record_timestamp_decoder.sv -----
`timescale 1ns / 1ps

// Decodes logged sensor records into a channel, a 12-bit reading and a calendar
// timestamp built from the start date in the csr_ registers plus the record's
// minute offset. One record is taken every cycle unless a stall on rsp_ backs
// up to the input. Each accepted record passes through the offset split (two
// reciprocal multiplies, four stages) and the minute/hour/day carry chain (three
// stages, the last being the output register) before rsp_tvalid rises for it.
// Records whose offset or sensor word is 0xFFFF are accepted and dropped. Stalls
// on rsp_ propagate stage by stage, so empty stages still take new records.
// Write the csr_ registers only while no record is in flight.
module sensor_record_timestamp_decoder
   import srtd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // minute_offset[15:0], raw_reading[31:16]

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // channel[3:0], reading[15:4], century[22:16], year[29:23], month[33:30],
   // day[38:34], hour[43:39], minute[49:44], zero[55:50]
   output logic [55:0]            rsp_tdata,

   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff;
   logic      split_valid;
   logic      split_ready;
   split_type split_data;
   rslt_type  rslt;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.century <= 7'd20;
         cfg_ff.year    <= 7'd0;
         cfg_ff.month   <= 4'd1;
         cfg_ff.day     <= 5'd1;
         cfg_ff.hour    <= 5'd0;
         cfg_ff.minute  <= 6'd0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_START_CENTURY: cfg_ff.century <= csr_wdata;
            CSR_START_YEAR:    cfg_ff.year    <= csr_wdata;
            CSR_START_MONTH:   cfg_ff.month   <= csr_wdata[3:0];
            CSR_START_DAY:     cfg_ff.day     <= csr_wdata[4:0];
            CSR_START_HOUR:    cfg_ff.hour    <= csr_wdata[4:0];
            CSR_START_MINUTE:  cfg_ff.minute  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   srtd_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_offset (req_tdata[15:0]),
      .in_raw    (req_tdata[31:16]),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   srtd_cal u_cal (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rslt)
   );

   assign rsp_tdata = {6'd0, rslt};

endmodule

// ----- rtl/core/srtd_checker.sv -----
`timescale 1ns / 1ps

module srtd_checker
   import srtd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   rslt_type rslt;

   assign rslt = rsp_tdata[$bits(rslt_type)-1:0];

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // an empty output stage means every stage can advance
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rslt.minute < 6'd60 && rslt.hour < 5'd24
                     && rslt.month <= 4'd12 && rslt.year <= 7'd99)
      else $error("timestamp field out of range");

endmodule

bind sensor_record_timestamp_decoder srtd_checker u_srtd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/sensor_record_timestamp_decoder_tb.sv -----
`timescale 1ns / 1ps

module sensor_record_timestamp_decoder_tb;
   import srtd_pkg::*;

   localparam int unsigned RESULT_LATENCY    = 7;
   localparam int unsigned DRAIN_CYCLES      = 4 * RESULT_LATENCY;
   localparam int unsigned CYCLE_LIMIT       = 500000;
   localparam int unsigned RECORDS_PER_PHASE = 375;
   localparam int unsigned DATES_PER_PHASE   = 3;
   localparam int unsigned MAX_REPORTS       = 40;

   // indexes past the last register; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset;

   logic                   req_tvalid;
   logic                   req_tready;
   logic [31:0]            req_tdata;   // minute_offset[15:0], raw_reading[31:16]

   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // channel[3:0], reading[15:4], century[22:16], year[29:23], month[33:30],
   // day[38:34], hour[43:39], minute[49:44], zero[55:50]
   logic [55:0]            rsp_tdata;

   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cfg_type                start_date;
   rslt_type               pending_stamps[$];
   int unsigned            req_idle_pct;
   int unsigned            rsp_stall_pct;
   int unsigned            error_count;
   int unsigned            cycle_count;

   sensor_record_timestamp_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit decode_record(input cfg_type base, input logic [31:0] beat,
                                        output rslt_type stamp);
      int unsigned offset, days, rest, hours, mins;
      int unsigned century, year, month, day, hour, minute, month_len;
      stamp = '0;
      if (beat[15:0] == EMPTY_WORD || beat[31:16] == EMPTY_WORD)
         return 1'b0;
      offset = 32'(beat[15:0]);
      days   = offset / MIN_PER_DAY;
      rest   = offset % MIN_PER_DAY;
      hours  = rest / MIN_PER_HOUR;
      mins   = rest % MIN_PER_HOUR;

      century = 32'(base.century);
      year    = 32'(base.year);
      month   = 32'(base.month);
      day     = 32'(base.day) + days;
      hour    = 32'(base.hour) + hours;
      minute  = 32'(base.minute) + mins;

      // each field carries at most once, even with out-of-range start values
      if (minute >= MIN_PER_HOUR) begin
         hour++;
         minute = minute % MIN_PER_HOUR;
      end
      if (hour >= HOURS_PER_DAY) begin
         day++;
         hour = hour % HOURS_PER_DAY;
      end
      case (month)
         1, 3, 5, 7, 8, 10, 12: month_len = 31;
         2: month_len = (year % 4 == 0) ? 29 : 28;
         default: month_len = 30;
      endcase
      if (day > month_len) begin
         month++;
         day = day % month_len;
      end
      if (month > MONTH_TOP) begin
         year++;
         month = 1;
      end
      if (year > YEAR_TOP) begin
         century++;
         year = 0;
      end

      stamp.channel = beat[19:16];
      stamp.reading = beat[31:20];
      stamp.century = century[6:0];
      stamp.year    = year[6:0];
      stamp.month   = month[3:0];
      stamp.day     = day[4:0];
      stamp.hour    = hour[4:0];
      stamp.minute  = minute[5:0];
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : track_records
      rslt_type stamp;
      if (!reset && req_tvalid && req_tready) begin
         if (decode_record(start_date, req_tdata, stamp))
            pending_stamps.push_back(stamp);
      end
   end

   always @(posedge clock) begin : check_results
      rslt_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[49:0];
         if (pending_stamps.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected beat, expected none, got %h", $time, rsp_tdata);
         end else begin
            want = pending_stamps.pop_front();
            check_field("channel", 32'(want.channel), 32'(got.channel));
            check_field("reading", 32'(want.reading), 32'(got.reading));
            check_field("century", 32'(want.century), 32'(got.century));
            check_field("year", 32'(want.year), 32'(got.year));
            check_field("month", 32'(want.month), 32'(got.month));
            check_field("day", 32'(want.day), 32'(got.day));
            check_field("hour", 32'(want.hour), 32'(got.hour));
            check_field("minute", 32'(want.minute), 32'(got.minute));
            check_field("padding", 32'd0, 32'(rsp_tdata[55:50]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_record(input logic [15:0] offset, input logic [15:0] raw);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {raw, offset};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid, let every expected beat arrive, then flush dropped records
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_stamps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_start_date(input int unsigned century, input int unsigned year,
                                 input int unsigned month, input int unsigned day,
                                 input int unsigned hour, input int unsigned minute);
      cfg_type date;
      date.century = century[6:0];
      date.year    = year[6:0];
      date.month   = month[3:0];
      date.day     = day[4:0];
      date.hour    = hour[4:0];
      date.minute  = minute[5:0];
      wait_idle();
      write_reg(CSR_START_CENTURY, date.century);
      write_reg(CSR_START_YEAR, date.year);
      write_reg(CSR_START_MONTH, date.month);
      write_reg(CSR_START_DAY, date.day);
      write_reg(CSR_START_HOUR, date.hour);
      write_reg(CSR_START_MINUTE, date.minute);
      write_reg($urandom_range(1) ? CSR_UNUSED_HI : CSR_UNUSED_LO,
                CSR_DATA_W'($urandom_range(127)));
      csr_wen    <= 1'b0;
      start_date = date;
   endtask

   // start date left at its reset value: 2000-01-01 00:00
   task automatic test_reset_date();
      send_record(16'd0, 16'h0000);
      send_record(16'd59, 16'hFFFE);
      send_record(16'd60, 16'h0001);
      send_record(16'd1439, 16'hFFEF);
      send_record(16'd1440, 16'h8000);
      send_record(16'hFFFE, 16'h7FFF);
      send_record(EMPTY_WORD, 16'h1234);
      send_record(16'd5, EMPTY_WORD);
      send_record(EMPTY_WORD, EMPTY_WORD);
   endtask

   task automatic test_calendar_carries();
      // carry ripples all the way into the century
      set_start_date(99, 99, 12, 31, 23, 59);
      send_record(16'd1, 16'h0123);
      set_start_date(127, 99, 12, 31, 23, 59);
      send_record(16'd1, 16'h4567);
      // leap February, then a plain one
      set_start_date(20, 4, 2, 28, 0, 0);
      send_record(16'd1440, 16'h0A51);
      send_record(16'd2880, 16'h0A52);
      set_start_date(20, 1, 2, 28, 0, 0);
      send_record(16'd1440, 16'h0A53);
      // offset spanning more than one month
      set_start_date(20, 0, 4, 30, 12, 30);
      send_record(16'd64800, 16'h3C04);
      // modulo carry landing on day zero
      set_start_date(20, 0, 1, 31, 0, 0);
      send_record(16'd44640, 16'h0001);
   endtask

   task automatic test_register_extremes();
      set_start_date(0, 0, 1, 1, 0, 0);
      send_record(16'd0, 16'h0000);
      set_start_date(127, 127, 15, 31, 31, 63);
      send_record(16'hFFFE, 16'hFFFE);
      send_record(16'd1, 16'h0000);
      set_start_date(0, 0, 0, 0, 0, 0);
      send_record(16'd1439, 16'h0F0F);
      send_record(16'd59, 16'hF0F0);
   endtask

   task automatic test_random_records(input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      int unsigned sent;
      logic [15:0] offset, raw;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int d = 0; d < DATES_PER_PHASE; d++) begin
         if ($urandom_range(3) == 0)
            set_start_date($urandom_range(127), $urandom_range(127), $urandom_range(15),
                           $urandom_range(31), $urandom_range(31), $urandom_range(63));
         else
            set_start_date($urandom_range(99), $urandom_range(99), $urandom_range(1, 12),
                           $urandom_range(1, 31), $urandom_range(23), $urandom_range(59));
         sent = 0;
         while (sent < RECORDS_PER_PHASE / DATES_PER_PHASE) begin
            case ($urandom_range(9))
               0: offset = EMPTY_WORD;
               1: offset = 16'($urandom_range(MIN_PER_DAY - 1));
               2: offset = 16'($urandom_range(45) * MIN_PER_DAY + $urandom_range(1));
               3: offset = 16'($urandom_range(1092) * MIN_PER_HOUR);
               default: offset = 16'($urandom_range(16'hFFFE));
            endcase
            raw = ($urandom_range(9) == 0) ? EMPTY_WORD : 16'($urandom_range(16'hFFFF));
            send_record(offset, raw);
            sent++;
         end
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      rsp_tready    <= 1'b0;
      csr_wen       <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      error_count   = 0;
      cycle_count   = 0;
      start_date.century = 7'd20;
      start_date.year    = 7'd0;
      start_date.month   = 4'd1;
      start_date.day     = 5'd1;
      start_date.hour    = 5'd0;
      start_date.minute  = 6'd0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_date();
      test_calendar_carries();
      test_register_extremes();
      test_random_records(0, 0);
      test_random_records(77, 0);
      test_random_records(0, 77);
      test_random_records(30, 30);

      wait_idle();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/srtd_pkg.sv
rtl/core/srtd_split.sv
rtl/core/srtd_cal.sv
rtl/core/sensor_record_timestamp_decoder.sv
rtl/core/srtd_checker.sv
verif/sensor_record_timestamp_decoder_tb.sv
